[src/slri_pkg.sv]
// ----------------------------------------------------------------------------
// slri_pkg: shared types and constants of the sorted list block
// Command and status codes, storage sizes and the command record that
// travels from the front queue to the list engine.
// ----------------------------------------------------------------------------
package slri_pkg;

	// storage cells and the widths that follow from them
	localparam int CELLS = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int VAL_W = 32;

	// command codes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// status codes carried by every result of a command
	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2
	} status_t;

	// one queued command
	typedef struct packed {
		op_t                     op;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

[src/slri_front.sv]
// ----------------------------------------------------------------------------
// slri_front: command intake
// Accepts push transactions, decodes the command and holds up to two
// commands in a small queue for the list engine.
// ----------------------------------------------------------------------------
module slri_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           command,
	input  logic signed [slri_pkg::VAL_W-1:0] value,
	output logic                           cmd_valid,
	output slri_pkg::cmd_t                 cmd,
	input  logic                           cmd_take
);

	slri_pkg::cmd_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	// queue storage, classified on entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q].op    <= slri_pkg::op_t'(command);
			fifo_q[wr_ptr_q].value <= value;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/slri_back.sv]
// ----------------------------------------------------------------------------
// slri_back: list engine
// Holds the sorted cells, applies one insert or remove in a single pass over
// all cells in parallel, then streams the list into the result register.
// ----------------------------------------------------------------------------
module slri_back #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  slri_pkg::cmd_t                    cmd,
	output logic                              cmd_take,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic                              entry_present,
	output logic [slri_pkg::IDX_W-1:0]        entry_index,
	output logic signed [slri_pkg::VAL_W-1:0] entry_value,
	output logic                              last
);

	localparam int EFF_CAP = (CAPACITY < slri_pkg::CELLS) ? CAPACITY : slri_pkg::CELLS;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_EXEC   = 3'b010,
		S_STREAM = 3'b100
	} state_t;

	state_t                            state_q;
	slri_pkg::cmd_t                    cmd_q;
	logic signed [slri_pkg::VAL_W-1:0] cells_q [slri_pkg::CELLS];
	logic [slri_pkg::CNT_W-1:0]        count_q;
	logic [slri_pkg::IDX_W-1:0]        idx_q;
	slri_pkg::status_t                 stat_q;
	logic                              out_valid_q;

	logic [slri_pkg::CELLS-1:0]        lt;
	logic [slri_pkg::CELLS-1:0]        eq;
	logic [slri_pkg::CELLS-1:0]        after;
	logic                              run;
	logic signed [slri_pkg::VAL_W-1:0] ins_next [slri_pkg::CELLS];
	logic signed [slri_pkg::VAL_W-1:0] rem_next [slri_pkg::CELLS];
	logic                              found;
	logic                              can_ins;
	logic                              out_free;
	logic                              is_last;

	assign cmd_take = (state_q == S_IDLE);
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign is_last  = (count_q == '0)
		|| (({1'b0, idx_q} + slri_pkg::CNT_W'(1)) == count_q);
	assign can_ins  = (count_q < slri_pkg::CNT_W'(EFF_CAP));
	assign found    = |eq;

	// per-cell compares against the command value
	always_comb begin
		for (int i = 0; i < slri_pkg::CELLS; i++) begin
			lt[i] = (slri_pkg::CNT_W'(i) < count_q) && (cells_q[i] < cmd_q.value);
			eq[i] = (slri_pkg::CNT_W'(i) < count_q) && (cells_q[i] == cmd_q.value);
		end
	end

	// insert: cells below the slot stay, the slot takes the value, the rest move up
	always_comb begin
		ins_next[0] = lt[0] ? cells_q[0] : cmd_q.value;
		for (int i = 1; i < slri_pkg::CELLS; i++) begin
			if (lt[i])          ins_next[i] = cells_q[i];
			else if (lt[i-1])   ins_next[i] = cmd_q.value;
			else                ins_next[i] = cells_q[i-1];
		end
	end

	// remove: from the first match on, every cell but the top one takes its upper neighbor
	always_comb begin
		run = 1'b0;
		for (int i = 0; i < slri_pkg::CELLS; i++) begin
			run      = run | eq[i];
			after[i] = run;
		end
		for (int i = 0; i < slri_pkg::CELLS - 1; i++) begin
			rem_next[i] = after[i] ? cells_q[i+1] : cells_q[i];
		end
		rem_next[slri_pkg::CELLS-1] = cells_q[slri_pkg::CELLS-1];
	end

	// cell storage and command latch
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cmd_q <= cmd;
		if (state_q == S_EXEC) begin
			if (cmd_q.op == slri_pkg::OP_INSERT && can_ins) cells_q <= ins_next;
			else if (cmd_q.op == slri_pkg::OP_REMOVE && found) cells_q <= rem_next;
		end
	end

	// sequencer, count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			stat_q  <= slri_pkg::STAT_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					idx_q   <= '0;
					state_q <= S_STREAM;
					if (cmd_q.op == slri_pkg::OP_INSERT) begin
						if (can_ins) begin
							count_q <= count_q + slri_pkg::CNT_W'(1);
							stat_q  <= slri_pkg::STAT_DONE;
						end else begin
							stat_q  <= slri_pkg::STAT_FULL;
						end
					end else begin
						if (found) begin
							count_q <= count_q - slri_pkg::CNT_W'(1);
							stat_q  <= slri_pkg::STAT_DONE;
						end else begin
							stat_q  <= slri_pkg::STAT_MISS;
						end
					end
				end
				S_STREAM: begin
					if (out_free) begin
						if (is_last) state_q <= S_IDLE;
						else idx_q <= idx_q + slri_pkg::IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_STREAM && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (state_q == S_STREAM && out_free) begin
			status        <= stat_q;
			entry_present <= (count_q != '0);
			entry_index   <= (count_q != '0) ? idx_q : '0;
			entry_value   <= (count_q != '0) ? cells_q[idx_q] : '0;
			last          <= is_last;
		end
	end

endmodule

[src/sorted_list_insert_remove.sv]
// Order: with the engine idle, a pushed command is written into the front
// queue, latched by the engine, applied to the cells and then streamed into
// the result register.
// Rate: the engine takes the next command only after streaming the whole
// list, one stored entry per cycle while the result register is free.
// Reset: arst_n clears the queues and empties the list; cell contents are
// left as they are and are never shown before being written.
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: sorted list with insert and remove
// Front queue takes commands, the list engine applies them and streams the
// list after each command.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              command,
	input  logic signed [slri_pkg::VAL_W-1:0] value,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic                              entry_present,
	output logic [slri_pkg::IDX_W-1:0]        entry_index,
	output logic signed [slri_pkg::VAL_W-1:0] entry_value,
	output logic                              last
);

	logic           cmd_valid;
	logic           cmd_take;
	slri_pkg::cmd_t cmd;

	// command intake
	slri_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.value    (value),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// list engine
	slri_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.entry_present(entry_present),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.last         (last)
	);

endmodule

[src/slri_checker.sv]
// ----------------------------------------------------------------------------
// slri_port_checks: port-level checks of the sorted list block
// Watches result transactions for consistent entry fields.
// ----------------------------------------------------------------------------
module slri_port_checks (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic [1:0]                        status,
	input logic                              entry_present,
	input logic [slri_pkg::IDX_W-1:0]        entry_index,
	input logic signed [slri_pkg::VAL_W-1:0] entry_value,
	input logic                              last
);

	// an empty-list result is marked final and has zero fields
	a_empty_list_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !entry_present) |-> (last && entry_index == '0 && entry_value == '0))
		else $error("empty-list result malformed");

	// status code is always one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status == slri_pkg::STAT_DONE || status == slri_pkg::STAT_FULL
			|| status == slri_pkg::STAT_MISS))
		else $error("undefined status code");

	// a popped non-final entry is followed by the next index of the same command
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && entry_present && !last) ##1 !empty
			|-> (entry_index == $past(entry_index) + slri_pkg::IDX_W'(1)
				&& status == $past(status) && entry_present))
		else $error("stream index did not advance");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(entry_value) && $stable(last)))
		else $error("result changed while stalled");

endmodule

bind sorted_list_insert_remove slri_port_checks u_slri_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.status       (status),
	.entry_present(entry_present),
	.entry_index  (entry_index),
	.entry_value  (entry_value),
	.last         (last)
);

[bench/slri_checker.sv]
// ----------------------------------------------------------------------------
// slri_checker: scoreboard for the sorted list block
// Watches the command and result queues, keeps its own copy of the sorted
// list, predicts the streamed contents after every command and compares
// each popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module slri_checker
	import slri_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic                    command,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    empty,
	input  logic                    pop,
	input  logic [1:0]              status,
	input  logic                    entry_present,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [VAL_W-1:0] entry_value,
	input  logic                    last,
	output int                      errors,
	output int                      pending,
	output int                      results_checked,
	output int                      full_cmds,
	output int                      miss_cmds
);

	// one predicted result transaction
	typedef struct {
		status_t                 status;
		logic                    present;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} list_entry_t;

	// shadow copy of the sorted list
	logic signed [VAL_W-1:0] list_vals [CELLS];
	int                      list_len = 0;
	list_entry_t             expected_entries [$];

	int err_cnt = 0;
	int seen_cnt = 0;
	int full_cnt = 0;
	int miss_cnt = 0;

	// apply one command to the shadow list and queue the streamed contents
	function automatic void apply_command(input op_t op, input logic signed [VAL_W-1:0] v);
		status_t     st;
		int          pos;
		int          j;
		int          cap;
		list_entry_t rec;
		cap = (CAPACITY < CELLS) ? CAPACITY : CELLS;
		st = STAT_DONE;
		pos = 0;
		if (op == OP_INSERT) begin
			if (list_len >= cap) begin
				st = STAT_FULL;
			end else begin
				// new value goes ahead of the first entry that is not smaller
				while (pos < list_len && list_vals[pos] < v)
					pos++;
				for (j = list_len; j > pos; j--)
					list_vals[j] = list_vals[j-1];
				list_vals[pos] = v;
				list_len++;
			end
		end else begin
			while (pos < list_len && list_vals[pos] != v)
				pos++;
			if (pos >= list_len) begin
				st = STAT_MISS;
			end else begin
				for (j = pos; j + 1 < list_len; j++)
					list_vals[j] = list_vals[j+1];
				list_len--;
			end
		end
		if (st == STAT_FULL)
			full_cnt++;
		if (st == STAT_MISS)
			miss_cnt++;
		// an empty list still yields a single marker result
		if (list_len == 0) begin
			rec.status = st;
			rec.present = 1'b0;
			rec.index = '0;
			rec.value = '0;
			rec.last = 1'b1;
			expected_entries.push_back(rec);
		end else begin
			for (j = 0; j < list_len; j++) begin
				rec.status = st;
				rec.present = 1'b1;
				rec.index = IDX_W'(j);
				rec.value = list_vals[j];
				rec.last = (j + 1 == list_len);
				expected_entries.push_back(rec);
			end
		end
	endfunction

	// compare one popped result with the oldest prediction
	function automatic void check_result();
		list_entry_t want;
		seen_cnt++;
		if (expected_entries.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("result %0d: unexpected status %0d present %0d index %0d value %0d last %0d",
					seen_cnt, status, entry_present, entry_index, entry_value, last);
			return;
		end
		want = expected_entries.pop_front();
		if (status !== want.status || entry_present !== want.present ||
				entry_index !== want.index || entry_value !== want.value ||
				last !== want.last) begin
			err_cnt++;
			if (err_cnt <= 10) begin
				$display("result %0d: expected status %0d present %0d index %0d value %0d last %0d",
					seen_cnt, want.status, want.present, want.index, want.value, want.last);
				$display("result %0d:      got status %0d present %0d index %0d value %0d last %0d",
					seen_cnt, status, entry_present, entry_index, entry_value, last);
			end
		end
	endfunction

	// sample both queues at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_entries.delete();
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				apply_command(op_t'(command), value);
		end
		errors <= err_cnt;
		pending <= expected_entries.size();
		results_checked <= seen_cnt;
		full_cmds <= full_cnt;
		miss_cmds <= miss_cnt;
	end

endmodule

[bench/tb_sorted_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove: testbench for the sorted list block
// Directed inserts and removes at the value extremes, duplicates, misses and
// a full list, then random command mixes that swing the list between empty
// and full, with random idle bursts on both queues; the checker scores it.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_remove;
	import slri_pkg::*;

	localparam int CAP        = 16;
	localparam int RAND_ITEMS = 305;
	localparam int CALM_FROM  = 245;
	localparam int IDLE_LIMIT = 2000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	logic                    command = OP_INSERT;
	logic signed [VAL_W-1:0] value = '0;
	logic                    empty;
	logic                    pop = 1'b0;
	logic [1:0]              status;
	logic                    entry_present;
	logic [IDX_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last;

	int errors;
	int pending;
	int results_checked;
	int full_cmds;
	int miss_cmds;

	logic                    calm = 1'b0;
	int                      pop_hold = 0;
	int                      idle_cycles = 0;
	int                      n_insert = 0;
	int                      n_remove = 0;
	logic signed [VAL_W-1:0] pool [8];

	sorted_list_insert_remove #(.CAPACITY(CAP)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.value(value), .empty(empty), .pop(pop), .status(status),
		.entry_present(entry_present), .entry_index(entry_index),
		.entry_value(entry_value), .last(last)
	);

	slri_checker #(.CAPACITY(CAP)) u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.value(value), .empty(empty), .pop(pop), .status(status),
		.entry_present(entry_present), .entry_index(entry_index),
		.entry_value(entry_value), .last(last), .errors(errors),
		.pending(pending), .results_checked(results_checked),
		.full_cmds(full_cmds), .miss_cmds(miss_cmds)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side: pop with random stall bursts
	always @(posedge clk) begin
		if (pop_hold > 0)
			pop_hold--;
		else if (!calm && $urandom_range(0, 7) == 0)
			pop_hold = $urandom_range(1, 8);
		pop <= (pop_hold == 0);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// issue one command, possibly after an idle burst
	task automatic send(input op_t op, input logic signed [VAL_W-1:0] v);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		command <= op;
		value <= v;
		if (op == OP_INSERT)
			n_insert++;
		else
			n_remove++;
		do @(posedge clk); while (full);
	endtask

	// hold off until every predicted result has been popped
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// half pool values so removes hit, plus extremes and raw random
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return pool[$urandom_range(0, 7)];
			5: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int i;
		int k;
		op_t op;
		for (k = 0; k < 8; k++)
			pool[k] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty miss, extremes, duplicates, removes, then overflow
		send(OP_REMOVE, 32'sd7);
		send(OP_INSERT, 32'sh7fff_ffff);
		send(OP_INSERT, 32'sh8000_0000);
		send(OP_INSERT, 32'sd0);
		send(OP_INSERT, -32'sd1);
		send(OP_INSERT, 32'sd0);
		send(OP_REMOVE, 32'sd12345);
		send(OP_REMOVE, 32'sd0);
		send(OP_REMOVE, 32'sh8000_0000);
		send(OP_REMOVE, 32'sh7fff_ffff);
		for (k = 0; k < CAP - 2; k++)
			send(OP_INSERT, $urandom);
		send(OP_INSERT, 32'sd1);

		wait_drained();

		// random: alternate fill and drain phases so the list spans empty to full
		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i == CALM_FROM)
				calm = 1'b1;
			if (i == RAND_ITEMS / 2)
				wait_drained();
			if (((i / 40) % 2) == 0)
				op = ($urandom_range(0, 3) != 0) ? OP_INSERT : OP_REMOVE;
			else
				op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_REMOVE;
			send(op, pick_value());
		end

		push <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d inserts and %0d removes, %0d result transactions checked",
			n_insert, n_remove, results_checked);
		$display("commands refused on a full list: %0d, removes that missed: %0d",
			full_cmds, miss_cmds);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
